/* rtl/core/cfs_pkg.sv */
// ----------------------------------------------------------------------------
// cfs_pkg
// Types and constants shared by the circle fill and outline shader core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfs_pkg;

  localparam int COL_W    = 11;
  localparam int DIM_W    = 12;
  localparam int POS_W    = 12;
  localparam int RAD_W    = 11;
  localparam int CHAN_W   = 8;
  localparam int RGB_W    = 24;
  localparam int OPA_W    = 7;
  localparam int COV_W    = 2;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam int DY_W     = 14;
  localparam int DX_W     = 13;
  localparam int ADY_W    = 13;
  localparam int DABS_W   = 12;
  localparam int RADSQ_W  = 2 * RAD_W;
  localparam int ROOT_W   = RAD_W;
  localparam int REM_W    = ROOT_W + 2;

  localparam int SQRT_PER_STAGE = 3;
  localparam int SQRT_STAGES    = (ROOT_W + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;

  localparam logic [OPA_W-1:0] OPACITY_RESET = 7'd100;
  localparam logic [OPA_W-1:0] OPACITY_FULL  = 7'd100;

  localparam logic [COV_W-1:0] COV_NONE    = 2'd0;
  localparam logic [COV_W-1:0] COV_FILL    = 2'd1;
  localparam logic [COV_W-1:0] COV_OUTLINE = 2'd2;

  localparam logic [2:0] REG_CENTER_X    = 3'd0;
  localparam logic [2:0] REG_CENTER_Y    = 3'd1;
  localparam logic [2:0] REG_RADIUS      = 3'd2;
  localparam logic [2:0] REG_FILL_RGB    = 3'd3;
  localparam logic [2:0] REG_OUTLINE_RGB = 3'd4;
  localparam logic [2:0] REG_OPACITY     = 3'd5;
  localparam logic [2:0] REG_WIDTH       = 3'd6;
  localparam logic [2:0] REG_HEIGHT      = 3'd7;

  // channel 2 is red, 1 green, 0 blue
  typedef logic [2:0][CHAN_W-1:0] rgb_t;

  typedef struct packed {
    logic [COL_W-1:0]  pixel_col;
    logic [COL_W-1:0]  pixel_row;
    logic [CHAN_W-1:0] bg_red;
    logic [CHAN_W-1:0] bg_green;
    logic [CHAN_W-1:0] bg_blue;
  } pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [COV_W-1:0]  coverage;
  } shade_t;

  typedef struct packed {
    logic signed [POS_W-1:0] center_x;
    logic signed [POS_W-1:0] center_y;
    logic [RAD_W-1:0]        circle_radius;
    logic [RGB_W-1:0]        fill_rgb;
    logic [RGB_W-1:0]        outline_rgb;
    logic [OPA_W-1:0]        opacity_percent;
    logic [DIM_W-1:0]        image_width;
    logic [DIM_W-1:0]        image_height;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [DABS_W-1:0]   d_abs;
    logic [RADSQ_W-1:0]  rad;
    rgb_t                bg;
  } geom_t;

  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [DABS_W-1:0]   d_abs;
    logic [RADSQ_W-1:0]  rad;
    logic [REM_W-1:0]    rem;
    logic [ROOT_W-1:0]   root;
  } sqrt_t;

  typedef struct packed {
    rgb_t bg;
    rgb_t mix;
  } blend_t;

endpackage

`default_nettype wire

/* rtl/core/cfs_geom.sv */
// ----------------------------------------------------------------------------
// cfs_geom
// Bounds test, row flip, offsets from the center and the radicand r*r-dy*dy,
// over four register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfs_geom #(
  parameter int MAX_DIM = 2048
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          pix_valid,
  input  wire cfs_pkg::pix_t pix,
  input  wire cfs_pkg::cfg_t cfg,
  output cfs_pkg::geom_t     geom
);

  typedef struct packed {
    logic                                 valid;
    logic                                 in_img;
    logic signed [cfs_pkg::DY_W-1:0]      dy;
    logic signed [cfs_pkg::DX_W-1:0]      dx;
    cfs_pkg::rgb_t                        bg;
  } sa_t;

  typedef struct packed {
    logic                                 valid;
    logic                                 hit;
    logic [cfs_pkg::RAD_W-1:0]            ady;
    logic [cfs_pkg::DABS_W-1:0]           d_abs;
    cfs_pkg::rgb_t                        bg;
  } sb_t;

  typedef struct packed {
    logic                                 valid;
    logic                                 hit;
    logic [cfs_pkg::RADSQ_W-1:0]          rr;
    logic [cfs_pkg::RADSQ_W-1:0]          aa;
    logic [cfs_pkg::DABS_W-1:0]           d_abs;
    cfs_pkg::rgb_t                        bg;
  } sc_t;

  sa_t sa, sa_next;
  sb_t sb, sb_next;
  sc_t sc, sc_next;
  cfs_pkg::geom_t sd_next;

  logic [cfs_pkg::DIM_W-1:0] w;
  logic [cfs_pkg::DIM_W-1:0] h;
  logic [cfs_pkg::DY_W-1:0]  ady_full;
  logic [cfs_pkg::DX_W-1:0]  dx_abs;

  always_comb begin
    w = (32'(cfg.image_width) > MAX_DIM) ? cfs_pkg::DIM_W'(MAX_DIM) : cfg.image_width;
    h = (32'(cfg.image_height) > MAX_DIM) ? cfs_pkg::DIM_W'(MAX_DIM) : cfg.image_height;

    sa_next.valid  = pix_valid;
    sa_next.in_img = ({1'b0, pix.pixel_col} < w) && ({1'b0, pix.pixel_row} < h);
    sa_next.dy     = $signed({2'b00, h}) - $signed(14'd1)
                     - $signed({3'b000, pix.pixel_row})
                     - cfs_pkg::DY_W'(cfg.center_y);
    sa_next.dx     = $signed({2'b00, pix.pixel_col}) - cfs_pkg::DX_W'(cfg.center_x);
    sa_next.bg     = {pix.bg_red, pix.bg_green, pix.bg_blue};

    ady_full       = sa.dy[cfs_pkg::DY_W-1] ? cfs_pkg::DY_W'(-sa.dy) : cfs_pkg::DY_W'(sa.dy);
    dx_abs         = sa.dx[cfs_pkg::DX_W-1] ? cfs_pkg::DX_W'(-sa.dx) : cfs_pkg::DX_W'(sa.dx);
    sb_next.valid  = sa.valid;
    sb_next.hit    = sa.in_img && (ady_full <= {3'b000, cfg.circle_radius});
    sb_next.ady    = ady_full[cfs_pkg::RAD_W-1:0];
    sb_next.d_abs  = dx_abs[cfs_pkg::DABS_W-1:0];
    sb_next.bg     = sa.bg;

    sc_next.valid  = sb.valid;
    sc_next.hit    = sb.hit;
    sc_next.rr     = cfs_pkg::RADSQ_W'(cfg.circle_radius) * cfs_pkg::RADSQ_W'(cfg.circle_radius);
    sc_next.aa     = cfs_pkg::RADSQ_W'(sb.ady) * cfs_pkg::RADSQ_W'(sb.ady);
    sc_next.d_abs  = sb.d_abs;
    sc_next.bg     = sb.bg;

    sd_next.valid  = sc.valid;
    sd_next.hit    = sc.hit;
    sd_next.d_abs  = sc.d_abs;
    sd_next.rad    = sc.rr - sc.aa;
    sd_next.bg     = sc.bg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.valid   <= 1'b0;
      sb.valid   <= 1'b0;
      sc.valid   <= 1'b0;
      geom.valid <= 1'b0;
    end else if (en) begin
      sa   <= sa_next;
      sb   <= sb_next;
      sc   <= sc_next;
      geom <= sd_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cfs_sqrt_stage.sv */
// ----------------------------------------------------------------------------
// cfs_sqrt_stage
// One register stage of the integer square root: a few restoring steps,
// two radicand bits and one root bit each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfs_sqrt_stage #(
  parameter int FIRST = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire cfs_pkg::sqrt_t din,
  output cfs_pkg::sqrt_t      dout
);

  cfs_pkg::sqrt_t nxt;
  logic [cfs_pkg::REM_W+1:0] cur;
  logic [cfs_pkg::REM_W+1:0] trial;

  always_comb begin
    nxt   = din;
    cur   = '0;
    trial = '0;
    for (int k = 0; k < cfs_pkg::SQRT_PER_STAGE; k++) begin
      if (FIRST + k < cfs_pkg::ROOT_W) begin
        cur     = {nxt.rem, nxt.rad[cfs_pkg::RADSQ_W-1 -: 2]};
        trial   = {2'b00, nxt.root, 2'b01};
        nxt.rad = {nxt.rad[cfs_pkg::RADSQ_W-3:0], 2'b00};
        if (cur >= trial) begin
          nxt.rem  = cfs_pkg::REM_W'(cur - trial);
          nxt.root = {nxt.root[cfs_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          nxt.rem  = cfs_pkg::REM_W'(cur);
          nxt.root = {nxt.root[cfs_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cfs_blend.sv */
// ----------------------------------------------------------------------------
// cfs_blend
// Fill blend (bg*(255-a) + fill*a) / 255 per channel over four stages,
// with the background carried alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfs_blend (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire cfs_pkg::rgb_t                 bg,
  input  wire logic [cfs_pkg::RGB_W-1:0]     fill_rgb,
  input  wire logic [cfs_pkg::OPA_W-1:0]     opacity_percent,
  output cfs_pkg::blend_t                    blend
);

  localparam logic [20:0] ALPHA_RECIP = 21'd1336965;  // 255 * ceil(2^19 / 100)
  localparam logic [15:0] DIV255_RECIP = 16'd32897;   // ceil(2^23 / 255)

  logic [27:0]               alpha_prod;
  logic [cfs_pkg::CHAN_W-1:0] alpha;
  cfs_pkg::rgb_t             fill;

  logic [2:0][15:0] pa;
  logic [2:0][15:0] pb;
  logic [2:0][15:0] sum;
  logic [2:0][31:0] prod;
  cfs_pkg::rgb_t    bg1;
  cfs_pkg::rgb_t    bg2;
  cfs_pkg::rgb_t    bg3;

  assign alpha_prod = 28'(opacity_percent) * 28'(ALPHA_RECIP);
  assign fill       = fill_rgb;

  always_ff @(posedge clk) begin
    if (opacity_percent >= cfs_pkg::OPACITY_FULL) begin
      alpha <= 8'hFF;
    end else begin
      alpha <= alpha_prod[26:19];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        pa[c]            <= 16'(bg[c]) * 16'(8'hFF - alpha);
        pb[c]            <= 16'(fill[c]) * 16'(alpha);
        sum[c]           <= pa[c] + pb[c];
        prod[c]          <= 32'(sum[c]) * 32'(DIV255_RECIP);
        blend.mix[c]     <= prod[c][30:23];
      end
      bg1      <= bg;
      bg2      <= bg1;
      bg3      <= bg2;
      blend.bg <= bg3;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/circle_fill_outline_shader_core.sv */
// ----------------------------------------------------------------------------
// circle_fill_outline_shader_core
// Shades a stream of framebuffer pixels with a filled, outlined circle.
// ----------------------------------------------------------------------------
// Pixel requests enter on pix/pix_valid/pix_stall; each gives one result on
// shade/shade_valid/shade_stall with the new color and a coverage code
// (0 unchanged, 1 fill blended, 2 outline written). Results keep request order.
// One request is accepted per cycle while pix_stall is low; each passes four
// geometry stages, four square root stages of three root bits each (two in
// the last) and the output register. Configuration must be written over the
// APB port (register i at byte 4*i) only while no request is in flight; the
// block does not enforce this. Reads return the stored values.
// Reset empties the pipeline and loads the register defaults (opacity 100,
// all others 0). While the receiver stalls with a result waiting, the whole
// pipeline holds and pix_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module circle_fill_outline_shader_core #(
  parameter int MAX_DIM = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cfs_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [cfs_pkg::DATA_W-1:0]    pwdata,
  output logic [cfs_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  input  wire logic                          pix_valid,
  output logic                               pix_stall,
  input  wire cfs_pkg::pix_t                 pix,
  output logic                               shade_valid,
  input  wire logic                          shade_stall,
  output cfs_pkg::shade_t                    shade
);

  cfs_pkg::cfg_t   cfg;
  cfs_pkg::geom_t  geom;
  cfs_pkg::blend_t blend;
  cfs_pkg::sqrt_t  sq [cfs_pkg::SQRT_STAGES+1];
  cfs_pkg::shade_t shade_next;
  cfs_pkg::rgb_t   color;
  cfs_pkg::rgb_t   outline;
  logic [cfs_pkg::COV_W-1:0] cov;
  logic            advance;
  logic            wr;
  logic [2:0]      reg_sel;
  logic [cfs_pkg::DABS_W-1:0] root_ext;

  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign reg_sel   = paddr[4:2];
  assign advance   = !(shade_valid && shade_stall);
  assign pix_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x        <= '0;
      cfg.center_y        <= '0;
      cfg.circle_radius   <= '0;
      cfg.fill_rgb        <= '0;
      cfg.outline_rgb     <= '0;
      cfg.opacity_percent <= cfs_pkg::OPACITY_RESET;
      cfg.image_width     <= '0;
      cfg.image_height    <= '0;
    end else if (wr) begin
      unique case (reg_sel)
        cfs_pkg::REG_CENTER_X:    cfg.center_x        <= pwdata[cfs_pkg::POS_W-1:0];
        cfs_pkg::REG_CENTER_Y:    cfg.center_y        <= pwdata[cfs_pkg::POS_W-1:0];
        cfs_pkg::REG_RADIUS:      cfg.circle_radius   <= pwdata[cfs_pkg::RAD_W-1:0];
        cfs_pkg::REG_FILL_RGB:    cfg.fill_rgb        <= pwdata[cfs_pkg::RGB_W-1:0];
        cfs_pkg::REG_OUTLINE_RGB: cfg.outline_rgb     <= pwdata[cfs_pkg::RGB_W-1:0];
        cfs_pkg::REG_OPACITY:     cfg.opacity_percent <= pwdata[cfs_pkg::OPA_W-1:0];
        cfs_pkg::REG_WIDTH:       cfg.image_width     <= pwdata[cfs_pkg::DIM_W-1:0];
        cfs_pkg::REG_HEIGHT:      cfg.image_height    <= pwdata[cfs_pkg::DIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      cfs_pkg::REG_CENTER_X:    prdata = cfs_pkg::DATA_W'(unsigned'(cfg.center_x));
      cfs_pkg::REG_CENTER_Y:    prdata = cfs_pkg::DATA_W'(unsigned'(cfg.center_y));
      cfs_pkg::REG_RADIUS:      prdata = cfs_pkg::DATA_W'(cfg.circle_radius);
      cfs_pkg::REG_FILL_RGB:    prdata = cfs_pkg::DATA_W'(cfg.fill_rgb);
      cfs_pkg::REG_OUTLINE_RGB: prdata = cfs_pkg::DATA_W'(cfg.outline_rgb);
      cfs_pkg::REG_OPACITY:     prdata = cfs_pkg::DATA_W'(cfg.opacity_percent);
      cfs_pkg::REG_WIDTH:       prdata = cfs_pkg::DATA_W'(cfg.image_width);
      cfs_pkg::REG_HEIGHT:      prdata = cfs_pkg::DATA_W'(cfg.image_height);
    endcase
  end

  cfs_geom #(
    .MAX_DIM(MAX_DIM)
  ) u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .pix_valid (pix_valid),
    .pix       (pix),
    .cfg       (cfg),
    .geom      (geom)
  );

  // blend latency matches the square root stages
  cfs_blend u_blend (
    .clk             (clk),
    .en              (advance),
    .bg              (geom.bg),
    .fill_rgb        (cfg.fill_rgb),
    .opacity_percent (cfg.opacity_percent),
    .blend           (blend)
  );

  assign sq[0] = '{valid: geom.valid, hit: geom.hit, d_abs: geom.d_abs, rad: geom.rad,
                   rem: '0, root: '0};

  for (genvar s = 0; s < cfs_pkg::SQRT_STAGES; s++) begin : g_sqrt
    cfs_sqrt_stage #(
      .FIRST(s * cfs_pkg::SQRT_PER_STAGE)
    ) u_stage (
      .clk  (clk),
      .rst  (rst),
      .en   (advance),
      .din  (sq[s]),
      .dout (sq[s+1])
    );
  end

  assign outline  = cfg.outline_rgb;
  assign root_ext = cfs_pkg::DABS_W'(sq[cfs_pkg::SQRT_STAGES].root);

  always_comb begin
    if (sq[cfs_pkg::SQRT_STAGES].hit && (sq[cfs_pkg::SQRT_STAGES].d_abs == root_ext)) begin
      color = outline;
      cov   = cfs_pkg::COV_OUTLINE;
    end else if (sq[cfs_pkg::SQRT_STAGES].hit && (sq[cfs_pkg::SQRT_STAGES].d_abs < root_ext)) begin
      color = blend.mix;
      cov   = cfs_pkg::COV_FILL;
    end else begin
      color = blend.bg;
      cov   = cfs_pkg::COV_NONE;
    end
    shade_next.out_red   = color[2];
    shade_next.out_green = color[1];
    shade_next.out_blue  = color[0];
    shade_next.coverage  = cov;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shade_valid <= 1'b0;
    end else if (advance) begin
      shade_valid <= sq[cfs_pkg::SQRT_STAGES].valid;
      shade       <= shade_next;
    end
  end

endmodule

`default_nettype wire

/* tb/circle_fill_outline_shader_core_tb.sv */
// ----------------------------------------------------------------------------
// circle_fill_outline_shader_core_tb
// Self-checking bench for the circle fill and outline shader core.
// ----------------------------------------------------------------------------
// Programs the circle over APB, streams pixel requests with random gaps and
// random result stalls, and compares every result against a predicted color
// and coverage code held in a scoreboard. Starts with hand-picked pixels on
// the circle edge, inside, outside and off the image, then runs random
// circles with pixels on the rim, in the span around it or anywhere.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circle_fill_outline_shader_core_tb;
  import cfs_pkg::*;

  localparam int MAX_DIM = 2048;

  class shade_checker;
    cfg_t   regs;
    shade_t expected_shades[$];
    int     errors;

    function new();
      regs = '0;
      regs.opacity_percent = OPACITY_RESET;
      errors = 0;
    endfunction

    function int int_sqrt(int n);
      int root;
      int b;
      int t;
      root = 0;
      for (b = 11; b >= 0; b--) begin
        t = root | (1 << b);
        if (t * t <= n) root = t;
      end
      return root;
    endfunction

    function void write_reg(logic [2:0] idx, logic [DATA_W-1:0] v);
      case (idx)
        REG_CENTER_X:    regs.center_x = v[POS_W-1:0];
        REG_CENTER_Y:    regs.center_y = v[POS_W-1:0];
        REG_RADIUS:      regs.circle_radius = v[RAD_W-1:0];
        REG_FILL_RGB:    regs.fill_rgb = v[RGB_W-1:0];
        REG_OUTLINE_RGB: regs.outline_rgb = v[RGB_W-1:0];
        REG_OPACITY:     regs.opacity_percent = v[OPA_W-1:0];
        REG_WIDTH:       regs.image_width = v[DIM_W-1:0];
        REG_HEIGHT:      regs.image_height = v[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function shade_t shade_pixel(pix_t p);
      int w, h, col, row, cx, cy, r, dy, ady, dx, d, a, i;
      logic [CHAN_W-1:0] bg[3];
      logic [CHAN_W-1:0] fc[3];
      logic [CHAN_W-1:0] res[3];
      shade_t s;
      w = (int'(regs.image_width) > MAX_DIM) ? MAX_DIM : int'(regs.image_width);
      h = (int'(regs.image_height) > MAX_DIM) ? MAX_DIM : int'(regs.image_height);
      col = int'(p.pixel_col);
      row = int'(p.pixel_row);
      cx = $signed(regs.center_x);
      cy = $signed(regs.center_y);
      r = int'(regs.circle_radius);
      bg = '{p.bg_red, p.bg_green, p.bg_blue};
      res = bg;
      s.coverage = COV_NONE;
      if (col < w && row < h) begin
        dy = h - 1 - row - cy;
        ady = (dy < 0) ? -dy : dy;
        if (ady <= r) begin
          dx = int_sqrt(r * r - ady * ady);
          d = col - cx;
          if (d < 0) d = -d;
          if (d == dx) begin
            s.coverage = COV_OUTLINE;
            res = '{regs.outline_rgb[23:16], regs.outline_rgb[15:8], regs.outline_rgb[7:0]};
          end else if (d < dx) begin
            s.coverage = COV_FILL;
            fc = '{regs.fill_rgb[23:16], regs.fill_rgb[15:8], regs.fill_rgb[7:0]};
            a = int'(regs.opacity_percent) * 255 / 100;
            if (a > 255) a = 255;
            for (i = 0; i < 3; i++) begin
              if (regs.opacity_percent == OPACITY_FULL) begin
                res[i] = fc[i];
              end else begin
                res[i] = CHAN_W'((int'(bg[i]) * (255 - a) + int'(fc[i]) * a) / 255);
              end
            end
          end
        end
      end
      s.out_red = res[0];
      s.out_green = res[1];
      s.out_blue = res[2];
      return s;
    endfunction

    function void note_pixel(pix_t p);
      expected_shades.push_back(shade_pixel(p));
    endfunction

    function int pending();
      return expected_shades.size();
    endfunction

    function void check_shade(shade_t got);
      shade_t want;
      if (expected_shades.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: r=%0d g=%0d b=%0d cov=%0d",
                   got.out_red, got.out_green, got.out_blue, got.coverage);
        return;
      end
      want = expected_shades.pop_front();
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue || got.coverage !== want.coverage) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected r=%0d g=%0d b=%0d cov=%0d, got r=%0d g=%0d b=%0d cov=%0d",
                   want.out_red, want.out_green, want.out_blue, want.coverage,
                   got.out_red, got.out_green, got.out_blue, got.coverage);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                pix_valid = 1'b0;
  logic                pix_stall;
  pix_t                pix = '0;
  logic                shade_valid;
  logic                shade_stall = 1'b0;
  shade_t              shade;

  shade_checker sb = new();

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_off_req = 1'b0;
  int stall_left = 0;
  int hold_left = 0;
  int ph_cx, ph_cy, ph_r, ph_h;

  circle_fill_outline_shader_core u_top (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .pix_valid   (pix_valid),
    .pix_stall   (pix_stall),
    .pix         (pix),
    .shade_valid (shade_valid),
    .shade_stall (shade_stall),
    .shade       (shade)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAIL circle_fill_outline_shader_core");
    $finish;
  end

  function automatic int idle_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (pix_valid && !pix_stall) sb.note_pixel(pix);
      if (shade_valid && !shade_stall) sb.check_shade(shade);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      shade_stall <= 1'b0;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left = 299;
      shade_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      shade_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      shade_stall <= 1'b1;
    end else begin
      shade_stall <= 1'b0;
      if (rx_idle) stall_left = idle_len();
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
  endtask

  task automatic set_circle(int cx, int cy, int r, int fill, int outline, int opa,
                            int w, int h);
    apb_write(REG_CENTER_X, DATA_W'(cx) & 32'hfff);
    apb_write(REG_CENTER_Y, DATA_W'(cy) & 32'hfff);
    apb_write(REG_RADIUS, DATA_W'(r));
    apb_write(REG_FILL_RGB, DATA_W'(fill));
    apb_write(REG_OUTLINE_RGB, DATA_W'(outline));
    apb_write(REG_OPACITY, DATA_W'(opa));
    apb_write(REG_WIDTH, DATA_W'(w));
    apb_write(REG_HEIGHT, DATA_W'(h));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    ph_cx = cx;
    ph_cy = cy;
    ph_r = r;
    ph_h = (h > MAX_DIM) ? MAX_DIM : h;
  endtask

  task automatic send_req(pix_t p);
    int gap;
    gap = tx_idle ? idle_len() : 0;
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix <= p;
    do @(posedge clk); while (pix_stall);
  endtask

  task automatic drain();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  function automatic pix_t mk_pixel(int col, int row, int r, int g, int b);
    pix_t p;
    p.pixel_col = COL_W'(col);
    p.pixel_row = COL_W'(row);
    p.bg_red = CHAN_W'(r);
    p.bg_green = CHAN_W'(g);
    p.bg_blue = CHAN_W'(b);
    return p;
  endfunction

  function automatic pix_t random_pixel();
    int k, dy, dx, col, row, span;
    k = $urandom_range(0, 9);
    span = ph_r + 1;
    if (k < 2) begin
      col = $urandom_range(0, 2047);
      row = $urandom_range(0, 2047);
    end else if (k < 5) begin
      dy = $urandom_range(0, ph_r);
      dx = sb.int_sqrt(ph_r * ph_r - dy * dy);
      if ($urandom_range(0, 1)) dy = -dy;
      if ($urandom_range(0, 1)) dx = -dx;
      col = ph_cx + dx;
      row = ph_h - 1 - ph_cy - dy;
    end else begin
      dy = int'($urandom_range(0, 2 * span)) - span;
      col = ph_cx + int'($urandom_range(0, 2 * span)) - span;
      row = ph_h - 1 - ph_cy - dy;
    end
    return mk_pixel(col, row, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255));
  endfunction

  task automatic random_circle();
    int w, h, wc, hc, cx, cy, r, opa, k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      w = 4095;
      h = 4095;
    end else if (k == 1) begin
      w = 2048;
      h = 2048;
    end else begin
      w = $urandom_range(1, 300);
      h = $urandom_range(1, 300);
    end
    wc = (w > MAX_DIM) ? MAX_DIM : w;
    hc = (h > MAX_DIM) ? MAX_DIM : h;
    cx = $urandom_range(0, wc - 1);
    cy = $urandom_range(0, hc - 1);
    if ($urandom_range(0, 9) == 0) cx = -2048;
    if ($urandom_range(0, 9) == 0) cy = 2047;
    k = $urandom_range(0, 9);
    if (k == 0) r = 0;
    else if (k == 1) r = 2047;
    else r = $urandom_range(0, 2 + ((wc < hc) ? wc : hc) / 2);
    k = $urandom_range(0, 9);
    if (k < 2) opa = 100;
    else if (k == 2) opa = 0;
    else if (k == 3) opa = $urandom_range(101, 127);
    else opa = $urandom_range(0, 99);
    set_circle(cx, cy, r, $urandom & 32'hffffff, $urandom & 32'hffffff, opa, w, h);
  endtask

  initial begin
    int opas[3];
    int i;
    int j;
    opas = '{0, 100, 127};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty image after reset
    send_req(mk_pixel(0, 0, 0, 0, 0));
    send_req(mk_pixel(2047, 2047, 255, 255, 255));
    drain();

    set_circle(20, 15, 10, 32'h123456, 32'ha5c3e1, 50, 64, 48);
    send_req(mk_pixel(20, 32, 0, 0, 0));
    send_req(mk_pixel(25, 32, 255, 255, 255));
    send_req(mk_pixel(30, 32, 1, 2, 3));
    send_req(mk_pixel(10, 32, 200, 100, 50));
    send_req(mk_pixel(31, 32, 9, 8, 7));
    send_req(mk_pixel(20, 22, 0, 255, 0));
    send_req(mk_pixel(21, 22, 255, 0, 255));
    send_req(mk_pixel(20, 42, 10, 20, 30));
    send_req(mk_pixel(20, 21, 40, 50, 60));
    send_req(mk_pixel(64, 32, 70, 80, 90));
    send_req(mk_pixel(20, 48, 11, 22, 33));
    send_req(mk_pixel(2047, 2047, 44, 55, 66));
    drain();

    for (i = 0; i < 3; i++) begin
      set_circle(20, 15, 10, 32'hfedcba, 32'h00ff00, opas[i], 64, 48);
      send_req(mk_pixel(20, 32, 255, 0, 128));
      send_req(mk_pixel(24, 30, 0, 255, 127));
      drain();
    end

    // oversize image, full radius
    set_circle(0, 0, 2047, 32'hffffff, 32'h000000, 1, 4095, 4095);
    send_req(mk_pixel(0, 0, 255, 255, 255));
    send_req(mk_pixel(0, 2047, 0, 0, 0));
    send_req(mk_pixel(2047, 2047, 128, 64, 32));
    send_req(mk_pixel(1000, 1000, 255, 255, 255));
    drain();

    // zero radius: single outline pixel
    set_circle(5, 5, 0, 32'h808080, 32'hffffff, 75, 16, 16);
    send_req(mk_pixel(5, 10, 1, 1, 1));
    send_req(mk_pixel(6, 10, 2, 2, 2));
    drain();

    set_circle(2047, -2048, 2047, 32'h0f0f0f, 32'hf0f0f0, 100, 2048, 2048);
    send_req(mk_pixel(2047, 0, 3, 3, 3));
    drain();

    for (i = 0; i < 8; i++) begin
      random_circle();
      tx_idle = (i % 4 != 3);
      rx_idle = (i % 4 != 1);
      if (i == 2) begin
        tx_idle = 1'b0;
        hold_off_req = 1'b1;
      end
      for (j = 0; j < 50; j++) begin
        if (i == 5 && j == 25) drain();
        send_req(random_pixel());
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS circle_fill_outline_shader_core");
    end else begin
      $display("FAIL circle_fill_outline_shader_core");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/cfs_pkg.sv
rtl/core/cfs_geom.sv
rtl/core/cfs_sqrt_stage.sv
rtl/core/cfs_blend.sv
rtl/core/circle_fill_outline_shader_core.sv
tb/circle_fill_outline_shader_core_tb.sv
